[rtl/low_end_focus_stereo_processor_defines.svh]
// Assertion macros used by the checker file of the low-end focus block.
`ifndef LOW_END_FOCUS_STEREO_PROCESSOR_DEFINES_SVH
`define LOW_END_FOCUS_STEREO_PROCESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LEFSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LEFSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lefsp_pkg.sv]
`timescale 1ns / 1ps

package lefsp_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEFF_BITS_DEF  = 16;

   localparam int STATE_W     = 32;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int SUB_GAIN_W  = 15;
   localparam int GAIN_SHIFT  = 14;

   localparam logic                  MODE_RST       = 1'b1;
   localparam logic [CSR_DATA_W-1:0] LOW_COEFF_RST  = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] SUB_COEFF_RST  = 16'd500;
   localparam logic [CSR_DATA_W-1:0] SLOW_COEFF_RST = 16'd214;
   localparam logic [CSR_DATA_W-1:0] WIDTH_GAIN_RST = 16'd16384;
   localparam logic [SUB_GAIN_W-1:0] SUB_GAIN_RST   = 15'd0;
   localparam logic [SUB_GAIN_W-1:0] TIGHT_GAIN_RST = 15'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEREO_MODE = 3'd0,
      CSR_LOW_COEFF   = 3'd1,
      CSR_SUB_COEFF   = 3'd2,
      CSR_SLOW_COEFF  = 3'd3,
      CSR_WIDTH_GAIN  = 3'd4,
      CSR_SUB_GAIN    = 3'd5,
      CSR_TIGHT_GAIN  = 3'd6
   } csr_index_type;

   // Operation issued to the shared multiplier.
   typedef enum logic [2:0] {
      OP_LOW    = 3'd0,
      OP_SUB    = 3'd1,
      OP_SLOW   = 3'd2,
      OP_WIDTH  = 3'd3,
      OP_GSUB   = 3'd4,
      OP_GTIGHT = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_APPLY = 4'b0100,
      ST_OUT   = 4'b1000
   } fsm_type;

endpackage

[rtl/low_end_focus_stereo_processor.sv]
`timescale 1ns / 1ps
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid, req_stall, req_left_in/right_in    | in
//  rsp     | rsp_valid, rsp_stall, rsp_left_out/right_out  | out
//  csr     | csr_write_en, csr_index, csr_wdata            | in
//
//  Each frame is worked one product at a time through the single multiplier,
//  with a multiply step and an apply step per product, 12 products in stereo and
//  5 in mono, then a hand-off of the result to the output register and a return to
//  idle, where the next frame is taken; no new frame is taken before the hand-off.
//  Reset is synchronous and restores the control and configuration registers and clears all channel state.
//  A result waits in the output register under rsp_stall while the next frame is taken.

module low_end_focus_stereo_processor #(
   parameter int SAMPLE_BITS = lefsp_pkg::SAMPLE_BITS_DEF,
   parameter int COEFF_BITS  = lefsp_pkg::COEFF_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [SAMPLE_BITS-1:0]           req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]           req_right_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]           rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]           rsp_right_out,
   input  logic                                    csr_write_en,
   input  logic [lefsp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lefsp_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lefsp_pkg::*;

   localparam int XSHIFT = STATE_W - SAMPLE_BITS;
   localparam int MULA_W = STATE_W + 2;
   localparam int MULB_W = ((COEFF_BITS > CSR_DATA_W) ? COEFF_BITS : CSR_DATA_W) + 1;
   localparam int PROD_W = MULA_W + MULB_W;
   localparam int SUM_W  = STATE_W + 4;
   localparam int ACC_W  = STATE_W + 8;

   localparam logic signed [SUM_W-1:0] STATE_HI =
      {{(SUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] STATE_LO = ~STATE_HI;
   localparam logic signed [ACC_W-1:0] OUT_HI =
      {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] OUT_LO = ~OUT_HI;

   function automatic logic [MULB_W-1:0] coeff_mask(input logic [CSR_DATA_W-1:0] v);
      logic [CSR_DATA_W+COEFF_BITS-1:0] wide;
      wide = {{COEFF_BITS{1'b0}}, v};
      return MULB_W'(wide[COEFF_BITS-1:0]);
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v > STATE_HI) ? STATE_HI : ((v < STATE_LO) ? STATE_LO : v);
      return STATE_W'(r);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v > OUT_HI) ? OUT_HI : ((v < OUT_LO) ? OUT_LO : v);
      return SAMPLE_BITS'(r);
   endfunction

   // control and channel state
   fsm_type                    state_ff, state_in;
   op_type                     op_ff, op_in;
   logic                       ch_ff, ch_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       mode_ff, mode_in;
   logic [CSR_DATA_W-1:0]      low_coeff_ff, low_coeff_in;
   logic [CSR_DATA_W-1:0]      sub_coeff_ff, sub_coeff_in;
   logic [CSR_DATA_W-1:0]      slow_coeff_ff, slow_coeff_in;
   logic [CSR_DATA_W-1:0]      width_gain_ff, width_gain_in;
   logic [SUB_GAIN_W-1:0]      sub_gain_ff, sub_gain_in;
   logic [SUB_GAIN_W-1:0]      tight_gain_ff, tight_gain_in;
   logic signed [STATE_W-1:0]  low_ff [2];
   logic signed [STATE_W-1:0]  low_in [2];
   logic signed [STATE_W-1:0]  sub_ff [2];
   logic signed [STATE_W-1:0]  sub_in [2];
   logic signed [STATE_W-1:0]  slow_ff [2];
   logic signed [STATE_W-1:0]  slow_in [2];
   logic [1:0]                 lastneg_ff, lastneg_in;
   logic [1:0]                 divneg_ff, divneg_in;

   // payload
   logic signed [SAMPLE_BITS-1:0] samp_ff [2];
   logic signed [SAMPLE_BITS-1:0] samp_in [2];
   logic signed [SAMPLE_BITS-1:0] res_ff [2];
   logic signed [SAMPLE_BITS-1:0] res_in [2];
   logic signed [ACC_W-1:0]       mix_ff [2];
   logic signed [ACC_W-1:0]       mix_in [2];
   logic signed [STATE_W-1:0]     mono_ff, mono_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;

   // datapath
   logic signed [STATE_W-1:0] x_c, low_c, sub_c, slow_c, sm_base, sm_val;
   logic signed [MULA_W-1:0]  tgt, mul_a;
   logic signed [MULB_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [SUM_W-1:0]   sm_sum;
   logic signed [ACC_W-1:0]   gain_term, fin_sum;
   logic signed [STATE_W:0]   mono_sum;

   assign x_c    = STATE_W'(samp_ff[ch_ff]) <<< XSHIFT;
   assign low_c  = low_ff[ch_ff];
   assign sub_c  = sub_ff[ch_ff];
   assign slow_c = slow_ff[ch_ff];

   // subharmonic target: |low| with the divider polarity applied
   assign tgt = ((low_c < 0) ^ divneg_ff[ch_ff]) ? -MULA_W'(low_c) : MULA_W'(low_c);

   always_comb begin
      case (op_ff)
         OP_LOW: begin
            mul_a = MULA_W'(x_c) - MULA_W'(low_c);
            mul_b = coeff_mask(low_coeff_ff);
         end
         OP_SUB: begin
            mul_a = tgt - MULA_W'(sub_c);
            mul_b = coeff_mask(sub_coeff_ff);
         end
         OP_SLOW: begin
            mul_a = MULA_W'(low_c) - MULA_W'(slow_c);
            mul_b = coeff_mask(slow_coeff_ff);
         end
         OP_WIDTH: begin
            mul_a = MULA_W'(low_c) - MULA_W'(mono_ff);
            mul_b = MULB_W'(width_gain_ff);
         end
         OP_GSUB: begin
            mul_a = MULA_W'(sub_c);
            mul_b = MULB_W'(sub_gain_ff);
         end
         OP_GTIGHT: begin
            mul_a = MULA_W'(low_c) - MULA_W'(slow_c);
            mul_b = MULB_W'(tight_gain_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      case (op_ff)
         OP_SUB:  sm_base = sub_c;
         OP_SLOW: sm_base = slow_c;
         default: sm_base = low_c;
      endcase
   end

   assign sm_sum    = SUM_W'(sm_base) + SUM_W'(prod_ff >>> COEFF_BITS);
   assign sm_val    = sat_state(sm_sum);
   assign gain_term = ACC_W'(prod_ff >>> GAIN_SHIFT);
   assign fin_sum   = acc_ff + gain_term;
   assign mono_sum  = (STATE_W+1)'(low_ff[0]) + (STATE_W+1)'(low_ff[1]);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      low_coeff_in  = low_coeff_ff;
      sub_coeff_in  = sub_coeff_ff;
      slow_coeff_in = slow_coeff_ff;
      width_gain_in = width_gain_ff;
      sub_gain_in   = sub_gain_ff;
      tight_gain_in = tight_gain_ff;
      low_in        = low_ff;
      sub_in        = sub_ff;
      slow_in       = slow_ff;
      lastneg_in    = lastneg_ff;
      divneg_in     = divneg_ff;
      samp_in       = samp_ff;
      res_in        = res_ff;
      mix_in        = mix_ff;
      mono_in       = mono_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               samp_in[0] = req_left_in;
               samp_in[1] = req_right_in;
               op_in      = OP_LOW;
               ch_in      = 1'b0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_MUL;
            case (op_ff)
               OP_LOW: begin
                  low_in[ch_ff] = sm_val;
                  // rising zero crossing of the lowpass flips the divider
                  if (lastneg_ff[ch_ff] && !sm_val[STATE_W-1]) begin
                     divneg_in[ch_ff] = ~divneg_ff[ch_ff];
                  end
                  lastneg_in[ch_ff] = sm_val[STATE_W-1];
                  op_in = OP_SUB;
               end
               OP_SUB: begin
                  sub_in[ch_ff] = sm_val;
                  op_in = OP_SLOW;
               end
               OP_SLOW: begin
                  slow_in[ch_ff] = sm_val;
                  if (mode_ff && !ch_ff) begin
                     ch_in = 1'b1;
                     op_in = OP_LOW;
                  end else if (mode_ff) begin
                     mono_in = STATE_W'(mono_sum >>> 1);
                     ch_in   = 1'b0;
                     op_in   = OP_WIDTH;
                  end else begin
                     mix_in[0] = ACC_W'(low_ff[0]);
                     op_in     = OP_GSUB;
                  end
               end
               OP_WIDTH: begin
                  mix_in[ch_ff] = ACC_W'(mono_ff) + gain_term;
                  ch_in = ~ch_ff;
                  op_in = ch_ff ? OP_GSUB : OP_WIDTH;
               end
               OP_GSUB: begin
                  acc_in = ACC_W'(x_c) - ACC_W'(low_c) + mix_ff[ch_ff] + gain_term;
                  op_in  = OP_GTIGHT;
               end
               OP_GTIGHT: begin
                  res_in[ch_ff] = sat_out(fin_sum >>> XSHIFT);
                  if (mode_ff && !ch_ff) begin
                     ch_in = 1'b1;
                     op_in = OP_GSUB;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_OUT: begin
            // hold until the output register is free or drains this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_left_in  = res_ff[0];
               rsp_right_in = mode_ff ? res_ff[1] : samp_ff[1];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_en) begin
         case (csr_index)
            CSR_STEREO_MODE: begin
               mode_in = csr_wdata[0];
               if (csr_wdata[0] != mode_ff) begin
                  for (int i = 0; i < 2; i++) begin
                     low_in[i]  = '0;
                     sub_in[i]  = '0;
                     slow_in[i] = '0;
                  end
                  lastneg_in = '0;
                  divneg_in  = '0;
               end
            end
            CSR_LOW_COEFF:  low_coeff_in  = csr_wdata;
            CSR_SUB_COEFF:  sub_coeff_in  = csr_wdata;
            CSR_SLOW_COEFF: slow_coeff_in = csr_wdata;
            CSR_WIDTH_GAIN: width_gain_in = csr_wdata;
            CSR_SUB_GAIN:   sub_gain_in   = csr_wdata[SUB_GAIN_W-1:0];
            CSR_TIGHT_GAIN: tight_gain_in = csr_wdata[SUB_GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_LOW;
         ch_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_RST;
         low_coeff_ff  <= LOW_COEFF_RST;
         sub_coeff_ff  <= SUB_COEFF_RST;
         slow_coeff_ff <= SLOW_COEFF_RST;
         width_gain_ff <= WIDTH_GAIN_RST;
         sub_gain_ff   <= SUB_GAIN_RST;
         tight_gain_ff <= TIGHT_GAIN_RST;
         for (int i = 0; i < 2; i++) begin
            low_ff[i]  <= '0;
            sub_ff[i]  <= '0;
            slow_ff[i] <= '0;
         end
         lastneg_ff    <= '0;
         divneg_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         ch_ff         <= ch_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_ff       <= mode_in;
         low_coeff_ff  <= low_coeff_in;
         sub_coeff_ff  <= sub_coeff_in;
         slow_coeff_ff <= slow_coeff_in;
         width_gain_ff <= width_gain_in;
         sub_gain_ff   <= sub_gain_in;
         tight_gain_ff <= tight_gain_in;
         low_ff        <= low_in;
         sub_ff        <= sub_in;
         slow_ff       <= slow_in;
         lastneg_ff    <= lastneg_in;
         divneg_ff     <= divneg_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff      <= samp_in;
      res_ff       <= res_in;
      mix_ff       <= mix_in;
      mono_ff      <= mono_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

[rtl/lefsp_checker.sv]
`timescale 1ns / 1ps
`include "low_end_focus_stereo_processor_defines.svh"

module lefsp_checker #(
   parameter int SAMPLE_BITS = lefsp_pkg::SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_left_out,
   input logic [SAMPLE_BITS-1:0] rsp_right_out
);
   import lefsp_pkg::*;

   `LEFSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result beat dropped while stalled")
   `LEFSP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_left_out) && $stable(rsp_right_out), "stalled result changed")
   // a frame keeps the block busy for the cycle after it is taken
   `LEFSP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "frame accepted back to back")
   // no result appears right behind an accept
   `LEFSP_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid), "result raised one cycle after accept")

endmodule

bind low_end_focus_stereo_processor lefsp_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_lefsp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import lefsp_pkg::*;

   localparam int SW          = SAMPLE_BITS_DEF;
   localparam int FRAC_SHIFT  = STATE_W - SAMPLE_BITS_DEF;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 9;
   localparam int PHASE_BEATS = 45;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [CSR_DATA_W-1:0]  ALL_ONES   = 16'hFFFF;
   localparam logic [CSR_DATA_W-1:0]  GAIN_UNITY = 16'd16384;
   localparam logic [CSR_DATA_W-1:0]  WIDTH_MAX  = 16'd32768;
   localparam logic signed [SW-1:0]   SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SW-1:0]   SAMPLE_MIN = 24'sh800000;

   typedef struct {
      logic [SW-1:0] left;
      logic [SW-1:0] right;
   } stereo_frame_type;

   // Tracks the filter state of both channels and the frames still due out.
   class focus_tracker_type;
      longint low_lvl[2], sub_lvl[2], slow_lvl[2];
      bit     low_was_neg[2], divider_neg[2];
      bit     stereo;
      int unsigned low_c, sub_c, slow_c, width_g, sub_g, tight_g;
      stereo_frame_type due[$];
      int mismatches;

      function new();
         stereo  = MODE_RST;
         low_c   = 32'(LOW_COEFF_RST);
         sub_c   = 32'(SUB_COEFF_RST);
         slow_c  = 32'(SLOW_COEFF_RST);
         width_g = 32'(WIDTH_GAIN_RST);
         sub_g   = 32'(SUB_GAIN_RST);
         tight_g = 32'(TIGHT_GAIN_RST);
         mismatches = 0;
         clear_channels();
      endfunction

      function void clear_channels();
         for (int c = 0; c < 2; c++) begin
            low_lvl[c] = 0;
            sub_lvl[c] = 0;
            slow_lvl[c] = 0;
            low_was_neg[c] = 0;
            divider_neg[c] = 0;
         end
      endfunction

      function longint clamp(longint v, int bits);
         longint hi, lo;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         return v > hi ? hi : (v < lo ? lo : v);
      endfunction

      function longint smooth(longint y, longint target, int unsigned coeff);
         return clamp(y + ((longint'(coeff) * (target - y)) >>> COEFF_BITS_DEF), STATE_W);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_STEREO_MODE: begin
               if (val[0] != stereo) clear_channels();
               stereo = val[0];
            end
            CSR_LOW_COEFF:  low_c   = 32'(val);
            CSR_SUB_COEFF:  sub_c   = 32'(val);
            CSR_SLOW_COEFF: slow_c  = 32'(val);
            CSR_WIDTH_GAIN: width_g = 32'(val);
            CSR_SUB_GAIN:   sub_g   = 32'(val[SUB_GAIN_W-1:0]);
            CSR_TIGHT_GAIN: tight_g = 32'(val[SUB_GAIN_W-1:0]);
            default: ;
         endcase
      endfunction

      function void advance(int c, longint x);
         longint low, mag;
         low = smooth(low_lvl[c], x, low_c);
         low_lvl[c] = low;
         // rising zero crossing of the lowpass flips the octave divider
         if (low_was_neg[c] && low >= 0) divider_neg[c] = !divider_neg[c];
         low_was_neg[c] = low < 0;
         mag = low < 0 ? -low : low;
         sub_lvl[c]  = smooth(sub_lvl[c], divider_neg[c] ? -mag : mag, sub_c);
         slow_lvl[c] = smooth(slow_lvl[c], low, slow_c);
      endfunction

      function logic [SW-1:0] mix_out(longint x, longint low_mix, int c);
         longint v;
         v = x - low_lvl[c] + low_mix
           + ((longint'(sub_g) * sub_lvl[c]) >>> GAIN_SHIFT)
           + ((longint'(tight_g) * (low_lvl[c] - slow_lvl[c])) >>> GAIN_SHIFT);
         v = clamp(v >>> FRAC_SHIFT, SW);
         return v[SW-1:0];
      endfunction

      function void take_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
         longint x0, x1, mono, mix0, mix1;
         stereo_frame_type f;
         x0 = longint'(l) <<< FRAC_SHIFT;
         x1 = longint'(r) <<< FRAC_SHIFT;
         if (stereo) begin
            advance(0, x0);
            advance(1, x1);
            mono = (low_lvl[0] + low_lvl[1]) >>> 1;
            mix0 = mono + (((low_lvl[0] - mono) * longint'(width_g)) >>> GAIN_SHIFT);
            mix1 = mono + (((low_lvl[1] - mono) * longint'(width_g)) >>> GAIN_SHIFT);
            f.left  = mix_out(x0, mix0, 0);
            f.right = mix_out(x1, mix1, 1);
         end else begin
            advance(0, x0);
            f.left  = mix_out(x0, low_lvl[0], 0);
            f.right = r;
         end
         due.push_back(f);
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_frame(logic [SW-1:0] l, logic [SW-1:0] r);
         stereo_frame_type w;
         if (due.size() == 0) begin
            report($sformatf("unexpected beat left %0d right %0d", $signed(l), $signed(r)));
         end else begin
            w = due.pop_front();
            if (l !== w.left)
               report($sformatf("left_out got %0d want %0d", $signed(l), $signed(w.left)));
            if (r !== w.right)
               report($sformatf("right_out got %0d want %0d", $signed(r), $signed(w.right)));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic signed [SW-1:0]   req_left_in;
   logic signed [SW-1:0]   req_right_in;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic signed [SW-1:0]   rsp_left_out;
   logic signed [SW-1:0]   rsp_right_out;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   focus_tracker_type tracker = new();
   bit no_idle  = 0;
   bit hold_req = 0;
   int quiet_cycles = 0;

   low_end_focus_stereo_processor u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_value(int unsigned hi);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return CSR_DATA_W'(hi);
         default: return CSR_DATA_W'($urandom_range(0, hi));
      endcase
   endfunction

   function automatic logic signed [SW-1:0] extreme_sample();
      case ($urandom_range(0, 3))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // check every result beat against the oldest frame due
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_frame(rsp_left_out, rsp_right_out);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver back-pressure: random stretches, plus one long hold on request
   initial begin : rsp_side
      int stretch;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 0;
            stretch = HOLD_CYCLES;
         end else begin
            stretch = pick_gap();
         end
         if (stretch > 0) begin
            rsp_stall <= 1'b1;
            repeat (stretch) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      tracker.write_reg(idx, val);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                             input int gap);
      req_valid    <= 1'b1;
      req_left_in  <= l;
      req_right_in <= r;
      do @(posedge clock); while (req_stall);
      tracker.take_frame(l, r);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.due.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure_phase(input int p);
      case (p)
         0: begin
            write_reg(CSR_STEREO_MODE, 16'd1);
            write_reg(CSR_LOW_COEFF, ALL_ONES);
            write_reg(CSR_SUB_COEFF, ALL_ONES);
            write_reg(CSR_SLOW_COEFF, ALL_ONES);
            write_reg(CSR_WIDTH_GAIN, ALL_ONES);
            write_reg(CSR_SUB_GAIN, ALL_ONES);
            write_reg(CSR_TIGHT_GAIN, ALL_ONES);
         end
         1: begin
            write_reg(CSR_LOW_COEFF, '0);
            write_reg(CSR_SUB_COEFF, '0);
            write_reg(CSR_SLOW_COEFF, '0);
            write_reg(CSR_WIDTH_GAIN, '0);
            write_reg(CSR_SUB_GAIN, '0);
            write_reg(CSR_TIGHT_GAIN, '0);
         end
         default: begin
            write_reg(CSR_STEREO_MODE, (p == 2) ? 16'd0 : 16'($urandom_range(0, 1)));
            write_reg(CSR_LOW_COEFF, pick_value(16'hFFFF));
            write_reg(CSR_SUB_COEFF, pick_value(16'hFFFF));
            write_reg(CSR_SLOW_COEFF, pick_value(16'hFFFF));
            write_reg(CSR_WIDTH_GAIN, pick_value(WIDTH_MAX));
            write_reg(CSR_SUB_GAIN, pick_value(GAIN_UNITY));
            write_reg(CSR_TIGHT_GAIN, pick_value(GAIN_UNITY));
         end
      endcase
   endtask

   // mostly square waves with noise so the lowpass crosses zero, plus raw and extreme beats
   task automatic random_burst(input int count, input int fast_beats);
      int amp, half, left_cnt, kind, noise;
      bit pos;
      logic signed [SW-1:0] l, r;
      amp = $urandom_range(1000, 8388000);
      half = $urandom_range(1, 24);
      left_cnt = 0;
      pos = 0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            amp = $urandom_range(1000, 8388000);
            half = $urandom_range(1, 24);
         end
         if (left_cnt == 0) begin
            pos = !pos;
            left_cnt = half;
         end
         left_cnt--;
         kind = $urandom_range(0, 9);
         noise = $urandom_range(0, 511) - 256;
         if (kind < 6) begin
            l = SW'(pos ? amp + noise : -amp + noise);
            r = SW'(pos ? -(amp / 2) + noise : (amp / 2) + noise);
         end else if (kind < 9) begin
            l = SW'($urandom);
            r = SW'($urandom);
         end else begin
            l = extreme_sample();
            r = extreme_sample();
         end
         send_frame(l, r, (i < fast_beats) ? 0 : pick_gap());
      end
   endtask

   initial begin : req_side
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_left_in  = '0;
      req_right_in = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: fast lowpass so crossings come quickly, full mix gains
      write_reg(CSR_LOW_COEFF, ALL_ONES);
      write_reg(CSR_SUB_COEFF, 16'h8000);
      write_reg(CSR_SLOW_COEFF, 16'h1000);
      write_reg(CSR_WIDTH_GAIN, WIDTH_MAX);
      write_reg(CSR_SUB_GAIN, GAIN_UNITY);
      write_reg(CSR_TIGHT_GAIN, GAIN_UNITY);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 0);
      send_frame(SAMPLE_MAX, SAMPLE_MAX, 1);
      send_frame(SAMPLE_MIN, SAMPLE_MIN, 0);
      send_frame('0, '0, 2);
      send_frame(SW'(-1), SW'(1), 0);
      for (int i = 0; i < 6; i++)
         send_frame(i[0] ? SAMPLE_MAX : SAMPLE_MIN, i[0] ? SAMPLE_MIN : SAMPLE_MAX, 0);
      drain();

      // mono through a write with stray upper bits; out-of-range index is dropped
      write_reg(CSR_STEREO_MODE, 16'h0002);
      write_reg(CSR_UNUSED, ALL_ONES);
      write_reg(CSR_SUB_GAIN, ALL_ONES);
      write_reg(CSR_WIDTH_GAIN, ALL_ONES);
      send_frame(SAMPLE_MAX, SAMPLE_MIN, 0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 0);
      send_frame(SW'(1), SW'(-1), 0);
      for (int i = 0; i < 4; i++)
         send_frame(i[0] ? SAMPLE_MAX : SAMPLE_MIN, '0, 0);
      drain();
      // same mode again keeps the channel state
      write_reg(CSR_STEREO_MODE, 16'd0);
      send_frame(SAMPLE_MIN, SAMPLE_MAX, 0);
      send_frame(SAMPLE_MAX, SW'(-1), 0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         configure_phase(p);
         no_idle = (p == 4);
         if (p == 3) begin
            // hold the receiver off while beats keep coming so the block backs up
            hold_req = 1;
            random_burst(PHASE_BEATS, 30);
         end else if (p == 5) begin
            random_burst(PHASE_BEATS / 2, 0);
            req_valid <= 1'b0;
            @(posedge clock);
            while (tracker.due.size() > 0) @(posedge clock);
            random_burst(PHASE_BEATS - PHASE_BEATS / 2, 0);
         end else begin
            random_burst(PHASE_BEATS, 0);
         end
         no_idle = 0;
      end

      drain();
      if (tracker.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
